### rtl/fpn_pkg.sv
// shared types, constants and helpers of the fractal noise block
package fpn_pkg;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int          VAL_W     = 20;
  localparam logic [16:0] ONE_Q16   = 17'd65536;
  localparam logic [23:0] FREQ_MAX  = 24'hFFFFFF;
  localparam logic [20:0] FADE_BIAS = 21'd655360;

  typedef enum logic [1:0] {
    CFG_BASE_FREQ    = 2'd0,
    CFG_OCTAVE_COUNT = 2'd1,
    CFG_PERSISTENCE  = 2'd2,
    CFG_LACUNARITY   = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [15:0] base_freq;
    logic [3:0]  octave_count;
    logic [15:0] persistence;
    logic [15:0] lacunarity;
  } cfg_t;

  typedef struct packed {
    logic               op;
    logic [7:0]         table_index;
    logic [7:0]         table_value;
    logic signed [23:0] x_coord;
    logic signed [23:0] y_coord;
  } item_t;

  typedef enum logic [4:0] {
    S_IDLE, S_PX, S_PY,
    S_R0, S_R1, S_R2, S_R3, S_R4, S_R5, S_R6, S_R7, S_R8, S_R9, S_R10,
    S_T2X, S_T3X, S_SX, S_T2Y, S_T3Y, S_SY,
    S_LLO, S_LHI, S_LN, S_ACC, S_AMP, S_FRQ,
    S_DIV, S_DIVW, S_OUT
  } state_t;

  // gradient dot product on the front lattice face
  function automatic logic signed [VAL_W-1:0] grad_dot(
    input logic [3:0]              h,
    input logic signed [VAL_W-1:0] dx,
    input logic signed [VAL_W-1:0] dy
  );
    logic signed [VAL_W-1:0] u;
    logic signed [VAL_W-1:0] v;
    u = (h < 4'd8) ? dx : dy;
    v = (h < 4'd4) ? dy : ((h == 4'd12 || h == 4'd14) ? dx : '0);
    return (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

endpackage

### rtl/fpn_front.sv
// input acceptance and short queue ahead of the noise engine
module fpn_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_operation,
  input  logic [7:0]            in_table_index,
  input  logic [7:0]            in_table_value,
  input  logic signed [23:0]    in_x_coord,
  input  logic signed [23:0]    in_y_coord,
  output logic                  q_valid,
  output fpn_pkg::item_t        q_item,
  input  logic                  q_pop
);

  fpn_pkg::item_t                   entry_r [fpn_pkg::QUEUE_DEPTH];
  logic [fpn_pkg::QPTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [fpn_pkg::QPTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [fpn_pkg::QCNT_W-1:0]       cnt_r, cnt_nxt;
  logic                             push, pop;
  fpn_pkg::item_t                   new_item;

  always_comb begin
    new_item.op          = (in_operation == fpn_pkg::OP_EVAL) ? fpn_pkg::OP_EVAL
                                                              : fpn_pkg::OP_LOAD;
    new_item.table_index = in_table_index;
    new_item.table_value = in_table_value;
    new_item.x_coord     = in_x_coord;
    new_item.y_coord     = in_y_coord;
  end

  assign in_stall = (cnt_r == fpn_pkg::QCNT_W'(fpn_pkg::QUEUE_DEPTH));
  assign q_valid  = (cnt_r != '0);
  assign q_item   = entry_r[rd_ptr_r];
  assign push     = in_valid && !in_stall;
  assign pop      = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == fpn_pkg::QPTR_W'(fpn_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                             : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == fpn_pkg::QPTR_W'(fpn_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                             : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= new_item;
    end
  end

endmodule

### rtl/fpn_div.sv
// restoring divider, one quotient bit per cycle
module fpn_div #(
  parameter int N_W = 39,
  parameter int D_W = 21
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [N_W-1:0] dividend,
  input  logic [D_W-1:0] divisor,
  output logic           done,
  output logic [N_W-1:0] quotient
);

  localparam int CNT_W = $clog2(N_W + 1);

  logic [D_W:0]     rem_r;
  logic [N_W-1:0]   quo_r;
  logic [D_W-1:0]   dvs_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [D_W:0]     rem_sh;
  logic             fits;

  assign rem_sh   = {rem_r[D_W-1:0], quo_r[N_W-1]};
  assign fits     = (rem_sh >= {1'b0, dvs_r});
  assign done     = done_r;
  assign quotient = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(N_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= fits ? (rem_sh - {1'b0, dvs_r}) : rem_sh;
      quo_r <= {quo_r[N_W-2:0], fits};
    end
  end

endmodule

### rtl/fpn_back.sv
// octave sequencer, permutation memory, normalising divide and result register
module fpn_back #(
  parameter int MAX_OCTAVES     = 8,
  parameter int COORD_FRAC_BITS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  fpn_pkg::item_t      q_item,
  output logic                q_pop,
  input  fpn_pkg::cfg_t       cfg,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [15:0]  out_noise_value
);

  localparam int OCT_W = $clog2(MAX_OCTAVES + 1);
  localparam int ACC_W = 35 + $clog2(MAX_OCTAVES + 1);
  localparam int SUM_W = 17 + $clog2(MAX_OCTAVES + 1);
  localparam int VW    = fpn_pkg::VAL_W;

  fpn_pkg::state_t state_r, state_nxt;

  logic [7:0]   perm_mem [256];
  logic [7:0]   rd_q_r;
  logic [7:0]   rd_addr;
  logic         mem_we;

  logic signed [23:0]       x_r, y_r;
  logic [23:0]              freq_r;
  logic [16:0]              amp_r;
  logic signed [ACC_W-1:0]  total_r;
  logic [SUM_W-1:0]         asum_r;
  logic [OCT_W-1:0]         oct_r, noct_r;
  logic [OCT_W-1:0]         noct_eff;
  logic [15:0]              fx_r, fy_r, t2_r, t3_r;
  logic [7:0]               cx_r, cy_r, ra_r, rb_r;
  logic [7:0]               tra_r, tra1_r, trb_r, trb1_r;
  logic [3:0]               haa_r, hab_r, hba_r, hbb_r;
  logic [20:0]              q_r;
  logic [16:0]              sx_r, sy_r;
  logic signed [VW-1:0]     lo_r, hi_r, n_r;

  logic signed [24:0]       mul_a, mul_b;
  logic signed [49:0]       mul_p;
  logic signed [49:0]       mul_sh;
  logic signed [VW-1:0]     rx0, rx1, ry0, ry1;
  logic signed [VW-1:0]     d_aa, d_ba, d_ab, d_bb;
  logic signed [VW-1:0]     lerp_base;
  logic signed [VW:0]       lerp_diff;
  logic signed [VW:0]       lerp_sum;
  logic [20:0]              q_calc;
  logic [33:0]              fade_s;
  logic [27:0]              freq_s;

  logic                     out_valid_r;
  logic signed [15:0]       out_noise_r;
  logic                     out_free;
  logic [ACC_W-1:0]         dvd_mag;
  logic [ACC_W-1:0]         quo;
  logic                     div_start;
  logic                     div_done;
  logic                     total_neg_r;
  logic signed [15:0]       result;

  // effective octave count
  always_comb begin
    if (cfg.octave_count == 4'd0) begin
      noct_eff = OCT_W'(1);
    end else if (int'(cfg.octave_count) > MAX_OCTAVES) begin
      noct_eff = OCT_W'(MAX_OCTAVES);
    end else begin
      noct_eff = OCT_W'(cfg.octave_count);
    end
  end

  // relative offsets and corner gradients
  always_comb begin
    rx0  = $signed({{(VW-16){1'b0}}, fx_r});
    ry0  = $signed({{(VW-16){1'b0}}, fy_r});
    rx1  = rx0 - $signed(VW'(fpn_pkg::ONE_Q16));
    ry1  = ry0 - $signed(VW'(fpn_pkg::ONE_Q16));
    d_aa = fpn_pkg::grad_dot(haa_r, rx0, ry0);
    d_ba = fpn_pkg::grad_dot(hba_r, rx1, ry0);
    d_ab = fpn_pkg::grad_dot(hab_r, rx0, ry1);
    d_bb = fpn_pkg::grad_dot(hbb_r, rx1, ry1);
  end

  // shared multiplier operand selection
  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    lerp_base = '0;
    lerp_diff = '0;
    unique case (state_r)
      fpn_pkg::S_PX: begin
        mul_a = {x_r[23], x_r};
        mul_b = {1'b0, freq_r};
      end
      fpn_pkg::S_PY: begin
        mul_a = {y_r[23], y_r};
        mul_b = {1'b0, freq_r};
      end
      fpn_pkg::S_T2X: begin
        mul_a = {9'd0, fx_r};
        mul_b = {9'd0, fx_r};
      end
      fpn_pkg::S_T3X: begin
        mul_a = {9'd0, t2_r};
        mul_b = {9'd0, fx_r};
      end
      fpn_pkg::S_T2Y: begin
        mul_a = {9'd0, fy_r};
        mul_b = {9'd0, fy_r};
      end
      fpn_pkg::S_T3Y: begin
        mul_a = {9'd0, t2_r};
        mul_b = {9'd0, fy_r};
      end
      fpn_pkg::S_SX, fpn_pkg::S_SY: begin
        mul_a = {9'd0, t3_r};
        mul_b = {4'd0, q_r};
      end
      fpn_pkg::S_LLO: begin
        lerp_base = d_aa;
        lerp_diff = (VW+1)'(d_ba) - (VW+1)'(d_aa);
        mul_a     = 25'(lerp_diff);
        mul_b     = {8'd0, sx_r};
      end
      fpn_pkg::S_LHI: begin
        lerp_base = d_ab;
        lerp_diff = (VW+1)'(d_bb) - (VW+1)'(d_ab);
        mul_a     = 25'(lerp_diff);
        mul_b     = {8'd0, sx_r};
      end
      fpn_pkg::S_LN: begin
        lerp_base = lo_r;
        lerp_diff = (VW+1)'(hi_r) - (VW+1)'(lo_r);
        mul_a     = 25'(lerp_diff);
        mul_b     = {8'd0, sy_r};
      end
      fpn_pkg::S_ACC: begin
        mul_a = 25'(n_r);
        mul_b = {8'd0, amp_r};
      end
      fpn_pkg::S_AMP: begin
        mul_a = {8'd0, amp_r};
        mul_b = {9'd0, cfg.persistence};
      end
      fpn_pkg::S_FRQ: begin
        mul_a = {1'b0, freq_r};
        mul_b = {9'd0, cfg.lacunarity};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p    = mul_a * mul_b;
  assign mul_sh   = mul_p >>> 16;
  assign lerp_sum = (VW+1)'(lerp_base) + mul_sh[VW:0];
  assign q_calc   = 21'(t2_r) * 21'd6 + fpn_pkg::FADE_BIAS
                  - 21'((state_r == fpn_pkg::S_T3X) ? fx_r : fy_r) * 21'd15;
  assign fade_s   = mul_p[49:16];
  assign freq_s   = mul_p[39:12];

  // table read address
  always_comb begin
    unique case (state_r)
      fpn_pkg::S_R0:  rd_addr = cx_r;
      fpn_pkg::S_R1:  rd_addr = cx_r + 8'd1;
      fpn_pkg::S_R2:  rd_addr = ra_r;
      fpn_pkg::S_R3:  rd_addr = ra_r + 8'd1;
      fpn_pkg::S_R4:  rd_addr = rb_r;
      fpn_pkg::S_R5:  rd_addr = rb_r + 8'd1;
      fpn_pkg::S_R6:  rd_addr = tra_r;
      fpn_pkg::S_R7:  rd_addr = tra1_r;
      fpn_pkg::S_R8:  rd_addr = trb_r;
      fpn_pkg::S_R9:  rd_addr = trb1_r;
      default:        rd_addr = cx_r;
    endcase
  end

  assign mem_we = (state_r == fpn_pkg::S_IDLE) && q_valid && (q_item.op == fpn_pkg::OP_LOAD);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      perm_mem[q_item.table_index] <= q_item.table_value;
    end
    rd_q_r <= perm_mem[rd_addr];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    div_start = 1'b0;
    unique case (state_r)
      fpn_pkg::S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_item.op == fpn_pkg::OP_EVAL) begin
            state_nxt = fpn_pkg::S_PX;
          end
        end
      end
      fpn_pkg::S_PX:  state_nxt = fpn_pkg::S_PY;
      fpn_pkg::S_PY:  state_nxt = fpn_pkg::S_R0;
      fpn_pkg::S_R0:  state_nxt = fpn_pkg::S_R1;
      fpn_pkg::S_R1:  state_nxt = fpn_pkg::S_R2;
      fpn_pkg::S_R2:  state_nxt = fpn_pkg::S_R3;
      fpn_pkg::S_R3:  state_nxt = fpn_pkg::S_R4;
      fpn_pkg::S_R4:  state_nxt = fpn_pkg::S_R5;
      fpn_pkg::S_R5:  state_nxt = fpn_pkg::S_R6;
      fpn_pkg::S_R6:  state_nxt = fpn_pkg::S_R7;
      fpn_pkg::S_R7:  state_nxt = fpn_pkg::S_R8;
      fpn_pkg::S_R8:  state_nxt = fpn_pkg::S_R9;
      fpn_pkg::S_R9:  state_nxt = fpn_pkg::S_R10;
      fpn_pkg::S_R10: state_nxt = fpn_pkg::S_T2X;
      fpn_pkg::S_T2X: state_nxt = fpn_pkg::S_T3X;
      fpn_pkg::S_T3X: state_nxt = fpn_pkg::S_SX;
      fpn_pkg::S_SX:  state_nxt = fpn_pkg::S_T2Y;
      fpn_pkg::S_T2Y: state_nxt = fpn_pkg::S_T3Y;
      fpn_pkg::S_T3Y: state_nxt = fpn_pkg::S_SY;
      fpn_pkg::S_SY:  state_nxt = fpn_pkg::S_LLO;
      fpn_pkg::S_LLO: state_nxt = fpn_pkg::S_LHI;
      fpn_pkg::S_LHI: state_nxt = fpn_pkg::S_LN;
      fpn_pkg::S_LN:  state_nxt = fpn_pkg::S_ACC;
      fpn_pkg::S_ACC: state_nxt = fpn_pkg::S_AMP;
      fpn_pkg::S_AMP: state_nxt = fpn_pkg::S_FRQ;
      fpn_pkg::S_FRQ: begin
        state_nxt = (oct_r + 1'b1 == noct_r) ? fpn_pkg::S_DIV : fpn_pkg::S_PX;
      end
      fpn_pkg::S_DIV: begin
        div_start = 1'b1;
        state_nxt = fpn_pkg::S_DIVW;
      end
      fpn_pkg::S_DIVW: begin
        if (div_done) begin
          state_nxt = fpn_pkg::S_OUT;
        end
      end
      fpn_pkg::S_OUT: begin
        if (out_free) begin
          state_nxt = fpn_pkg::S_IDLE;
        end
      end
      default: state_nxt = fpn_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fpn_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      fpn_pkg::S_IDLE: begin
        x_r     <= q_item.x_coord;
        y_r     <= q_item.y_coord;
        freq_r  <= {8'd0, cfg.base_freq};
        amp_r   <= fpn_pkg::ONE_Q16;
        total_r <= '0;
        asum_r  <= '0;
        oct_r   <= '0;
        noct_r  <= noct_eff;
      end
      fpn_pkg::S_PX: begin
        fx_r <= mul_p[COORD_FRAC_BITS +: 16];
        cx_r <= mul_p[COORD_FRAC_BITS + 16 +: 8];
      end
      fpn_pkg::S_PY: begin
        fy_r <= mul_p[COORD_FRAC_BITS +: 16];
        cy_r <= mul_p[COORD_FRAC_BITS + 16 +: 8];
      end
      fpn_pkg::S_R1:  ra_r   <= rd_q_r + cy_r;
      fpn_pkg::S_R2:  rb_r   <= rd_q_r + cy_r;
      fpn_pkg::S_R3:  tra_r  <= rd_q_r;
      fpn_pkg::S_R4:  tra1_r <= rd_q_r;
      fpn_pkg::S_R5:  trb_r  <= rd_q_r;
      fpn_pkg::S_R6:  trb1_r <= rd_q_r;
      fpn_pkg::S_R7:  haa_r  <= rd_q_r[3:0];
      fpn_pkg::S_R8:  hab_r  <= rd_q_r[3:0];
      fpn_pkg::S_R9:  hba_r  <= rd_q_r[3:0];
      fpn_pkg::S_R10: hbb_r  <= rd_q_r[3:0];
      fpn_pkg::S_T2X, fpn_pkg::S_T2Y: t2_r <= mul_p[31:16];
      fpn_pkg::S_T3X, fpn_pkg::S_T3Y: begin
        t3_r <= mul_p[31:16];
        q_r  <= q_calc;
      end
      fpn_pkg::S_SX: sx_r <= (fade_s > 34'(fpn_pkg::ONE_Q16)) ? fpn_pkg::ONE_Q16 : fade_s[16:0];
      fpn_pkg::S_SY: sy_r <= (fade_s > 34'(fpn_pkg::ONE_Q16)) ? fpn_pkg::ONE_Q16 : fade_s[16:0];
      fpn_pkg::S_LLO: lo_r <= lerp_sum[VW-1:0];
      fpn_pkg::S_LHI: hi_r <= lerp_sum[VW-1:0];
      fpn_pkg::S_LN:  n_r  <= lerp_sum[VW-1:0];
      fpn_pkg::S_ACC: begin
        total_r <= total_r + $signed(mul_p[ACC_W-1:0]);
        asum_r  <= asum_r + SUM_W'(amp_r);
      end
      fpn_pkg::S_AMP: amp_r <= mul_p[32:16];
      fpn_pkg::S_FRQ: begin
        freq_r <= (freq_s > 28'(fpn_pkg::FREQ_MAX)) ? fpn_pkg::FREQ_MAX : freq_s[23:0];
        oct_r  <= oct_r + 1'b1;
      end
      fpn_pkg::S_DIV: total_neg_r <= total_r[ACC_W-1];
      default: begin
      end
    endcase
  end

  assign dvd_mag = total_r[ACC_W-1] ? ACC_W'(-total_r) : ACC_W'(total_r);

  fpn_div #(
    .N_W (ACC_W),
    .D_W (SUM_W + 1)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dvd_mag),
    .divisor  ({asum_r, 1'b0}),
    .done     (div_done),
    .quotient (quo)
  );

  // truncation toward zero and saturation
  always_comb begin
    if (total_neg_r) begin
      result = (quo > ACC_W'(32768)) ? 16'sh8000 : $signed(16'(-quo));
    end else begin
      result = (quo > ACC_W'(32767)) ? 16'sh7FFF : $signed(quo[15:0]);
    end
  end

  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == fpn_pkg::S_OUT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == fpn_pkg::S_OUT && out_free) begin
      out_noise_r <= result;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_noise_value = out_noise_r;

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fpn_pkg::S_DIV) |-> (asum_r != '0))
    else $error("amplitude sum zero at divide");

  a_fade_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fpn_pkg::S_T2Y) |-> (sx_r <= fpn_pkg::ONE_Q16))
    else $error("fade weight out of range");

  a_oct_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fpn_pkg::S_FRQ) |-> (oct_r < noct_r))
    else $error("octave counter overrun");

  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == fpn_pkg::S_DIVW))
    else $error("divider finished outside wait");

endmodule

### rtl/fractal_perlin_noise.sv
// top level of the fractal gradient noise block
// A load transaction writes one byte of the 256-entry permutation table
// while the engine stays in its idle state. An evaluate transaction sums the
// configured octaves of 2D gradient noise and returns one Q1.15 value. The
// engine runs one shared 25x25 multiplier and one table read port in
// sequence: each octave makes its ten table reads in turn, and the
// normalising divide works through the dividend one bit at a time. A
// two-entry queue and an output register let input and output stall
// independently of the engine. The table must be fully loaded before the
// first evaluation; configuration is to be written by the user only while
// the block is idle, and the block itself does not enforce this.
module fractal_perlin_noise #(
  parameter int MAX_OCTAVES     = 8,
  parameter int COORD_FRAC_BITS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_operation,
  input  logic [7:0]         in_table_index,
  input  logic [7:0]         in_table_value,
  input  logic signed [23:0] in_x_coord,
  input  logic signed [23:0] in_y_coord,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_noise_value,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  fpn_pkg::cfg_t  cfg_r;
  logic           q_valid;
  logic           q_pop;
  fpn_pkg::item_t q_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base_freq    <= 16'd3604;
      cfg_r.octave_count <= 4'd6;
      cfg_r.persistence  <= 16'd31457;
      cfg_r.lacunarity   <= 16'd8397;
    end else if (cfg_valid && cfg_ready) begin
      unique case (fpn_pkg::cfg_idx_t'(cfg_index))
        fpn_pkg::CFG_BASE_FREQ:    cfg_r.base_freq    <= cfg_data;
        fpn_pkg::CFG_OCTAVE_COUNT: cfg_r.octave_count <= cfg_data[3:0];
        fpn_pkg::CFG_PERSISTENCE:  cfg_r.persistence  <= cfg_data;
        fpn_pkg::CFG_LACUNARITY:   cfg_r.lacunarity   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  fpn_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_table_index (in_table_index),
    .in_table_value (in_table_value),
    .in_x_coord     (in_x_coord),
    .in_y_coord     (in_y_coord),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop)
  );

  fpn_back #(
    .MAX_OCTAVES     (MAX_OCTAVES),
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop),
    .cfg             (cfg_r),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_noise_value (out_noise_value)
  );

endmodule

### tb/sv/tb_fractal_perlin_noise.sv
// self-checking testbench of the fractal gradient noise block
`timescale 1ns / 100ps

module tb_fractal_perlin_noise;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic               in_operation;
  logic [7:0]         in_table_index;
  logic [7:0]         in_table_value;
  logic signed [23:0] in_x_coord;
  logic signed [23:0] in_y_coord;
  logic               out_valid;
  logic               out_stall;
  logic signed [15:0] out_noise_value;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [1:0]         cfg_index;
  logic [15:0]        cfg_data;

  fractal_perlin_noise uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_operation(in_operation),
    .in_table_index(in_table_index), .in_table_value(in_table_value),
    .in_x_coord(in_x_coord), .in_y_coord(in_y_coord),
    .out_valid(out_valid), .out_stall(out_stall), .out_noise_value(out_noise_value),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  typedef struct {
    logic               op;
    logic [7:0]         ti;
    logic [7:0]         tv;
    logic signed [23:0] x;
    logic signed [23:0] y;
    bit                 known;
    logic signed [15:0] want;
  } row_t;

  localparam int N_ROWS    = 14;
  localparam int SETTLE    = 400;
  localparam int CYC_LIMIT = 4000000;

  logic [7:0]         perm_copy [256];
  logic [15:0]        scale_r;
  logic [3:0]         octaves_r;
  logic [15:0]        persist_r;
  logic [15:0]        lacun_r;
  logic signed [15:0] noise_q [$];
  int                 errors = 0;
  int                 cycles = 0;
  int                 send_idle_pct;
  int                 recv_idle_pct;
  row_t               rows [N_ROWS];

  always begin
    clk = 1'b1; #2;
    clk = 1'b0; #2;
  end

  function automatic longint fade(longint f);
    longint t2, t3, q, s;
    t2 = (f * f) >>> 16;
    t3 = (t2 * f) >>> 16;
    q  = 6 * t2 + 655360 - 15 * f;
    s  = (t3 * q) >>> 16;
    return (s > 65536) ? 65536 : s;
  endfunction

  function automatic longint blend(longint a, longint b, longint s);
    return a + (((b - a) * s) >>> 16);
  endfunction

  function automatic longint slope(logic [7:0] hv, longint dx, longint dy);
    logic [3:0] h;
    longint u, v;
    h = hv[3:0];
    u = (h < 8) ? dx : dy;
    v = (h < 4) ? dy : ((h == 12 || h == 14) ? dx : 0);
    return (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

  function automatic logic [7:0] pt(longint i);
    return perm_copy[i & 255];
  endfunction

  function automatic longint octave_val(longint x, longint y, longint freq);
    longint px, py, cx, cy, fx, fy, sx, sy, ra, rb, lo, hi;
    logic [7:0] haa, hab, hba, hbb;
    px = x * freq;
    py = y * freq;
    cx = (px >>> 24) & 255;
    cy = (py >>> 24) & 255;
    fx = (px >>> 8) & 65535;
    fy = (py >>> 8) & 65535;
    sx = fade(fx);
    sy = fade(fy);
    ra = pt(cx) + cy;
    rb = pt(cx + 1) + cy;
    haa = pt(pt(ra));
    hab = pt(pt(ra + 1));
    hba = pt(pt(rb));
    hbb = pt(pt(rb + 1));
    lo = blend(slope(haa, fx, fy), slope(hba, fx - 65536, fy), sx);
    hi = blend(slope(hab, fx, fy - 65536), slope(hbb, fx - 65536, fy - 65536), sx);
    return blend(lo, hi, sy);
  endfunction

  function automatic logic signed [15:0] fbm_noise(logic signed [23:0] x,
                                                   logic signed [23:0] y);
    longint freq, amp, total, amp_sum, r;
    int n;
    n = octaves_r;
    if (n == 0) n = 1;
    if (n > 8) n = 8;
    freq = scale_r;
    amp = 65536;
    total = 0;
    amp_sum = 0;
    for (int i = 0; i < n; i++) begin
      total += octave_val(longint'(x), longint'(y), freq) * amp;
      amp_sum += amp;
      amp = (amp * persist_r) >>> 16;
      freq = (freq * lacun_r) >>> 12;
      if (freq > 64'hFFFFFF) freq = 64'hFFFFFF;
    end
    r = total / (2 * amp_sum);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  task automatic send(logic op, logic [7:0] ti, logic [7:0] tv,
                      logic signed [23:0] x, logic signed [23:0] y,
                      bit known, logic signed [15:0] want);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_operation   <= op;
    in_table_index <= ti;
    in_table_value <= tv;
    in_x_coord     <= x;
    in_y_coord     <= y;
    do @(posedge clk); while (in_stall);
    if (op == fpn_pkg::OP_LOAD) perm_copy[ti] = tv;
    else noise_q.push_back(known ? want : fbm_noise(x, y));
  endtask

  task automatic write_reg(fpn_pkg::cfg_idx_t idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      fpn_pkg::CFG_BASE_FREQ:    scale_r   = val;
      fpn_pkg::CFG_OCTAVE_COUNT: octaves_r = val[3:0];
      fpn_pkg::CFG_PERSISTENCE:  persist_r = val;
      default:                   lacun_r   = val;
    endcase
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (noise_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic signed [23:0] rand_coord();
    if ($urandom_range(1)) return 24'($urandom);
    return 24'($signed($urandom_range(8191)) - 4096);
  endfunction

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
    if (rst_n && out_valid && !out_stall) begin
      if (noise_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0d", $time,
                 out_noise_value);
        errors++;
      end else begin
        if (out_noise_value !== noise_q[0]) begin
          $display("%0t: noise_value mismatch, expected %0d, actual %0d", $time,
                   noise_q[0], out_noise_value);
          errors++;
        end
        void'(noise_q.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYC_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    logic [7:0] shuf [256];
    logic [7:0] tmp;
    int j;
    logic [15:0] sets [6][4];
    send_idle_pct = 20;
    recv_idle_pct = 62;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_operation = fpn_pkg::OP_LOAD;
    in_table_index = '0;
    in_table_value = '0;
    in_x_coord = '0;
    in_y_coord = '0;
    cfg_valid = 1'b0;
    cfg_index = fpn_pkg::CFG_BASE_FREQ;
    cfg_data = '0;
    scale_r = 16'd3604;
    octaves_r = 4'd6;
    persist_r = 16'd31457;
    lacun_r = 16'd8397;
    for (int i = 0; i < 256; i++) perm_copy[i] = '0;

    rows[0]  = '{fpn_pkg::OP_EVAL, 8'd0, 8'd0, 24'sd0, 24'sd0, 1'b1, 16'sd0};
    rows[1]  = '{fpn_pkg::OP_EVAL, 8'hff, 8'hff, 24'sh7fffff, 24'sh7fffff, 1'b0, 16'sd0};
    rows[2]  = '{fpn_pkg::OP_EVAL, 8'd0, 8'd0, -24'sh800000, -24'sh800000, 1'b0, 16'sd0};
    rows[3]  = '{fpn_pkg::OP_EVAL, 8'd0, 8'd0, 24'sh7fffff, -24'sh800000, 1'b0, 16'sd0};
    rows[4]  = '{fpn_pkg::OP_EVAL, 8'd0, 8'd0, -24'sh800000, 24'sh7fffff, 1'b0, 16'sd0};
    rows[5]  = '{fpn_pkg::OP_LOAD, 8'd0, 8'hff, 24'sd0, 24'sd0, 1'b0, 16'sd0};
    rows[6]  = '{fpn_pkg::OP_LOAD, 8'hff, 8'd0, 24'sh7fffff, -24'sh800000, 1'b0, 16'sd0};
    rows[7]  = '{fpn_pkg::OP_EVAL, 8'd0, 8'd0, 24'sd1, 24'sd1, 1'b0, 16'sd0};
    rows[8]  = '{fpn_pkg::OP_EVAL, 8'd0, 8'd0, -24'sd1, -24'sd1, 1'b0, 16'sd0};
    rows[9]  = '{fpn_pkg::OP_EVAL, 8'd0, 8'd0, 24'sd128, -24'sd384, 1'b0, 16'sd0};
    rows[10] = '{fpn_pkg::OP_EVAL, 8'd0, 8'd0, 24'sd40000, 24'sd77777, 1'b0, 16'sd0};
    rows[11] = '{fpn_pkg::OP_LOAD, 8'h55, 8'haa, 24'sd0, 24'sd0, 1'b0, 16'sd0};
    rows[12] = '{fpn_pkg::OP_LOAD, 8'haa, 8'h55, 24'sd0, 24'sd0, 1'b0, 16'sd0};
    rows[13] = '{fpn_pkg::OP_EVAL, 8'd0, 8'd0, -24'sd123456, 24'sd654321, 1'b0, 16'sd0};

    sets[0] = '{16'd3604, 16'd6, 16'd31457, 16'd8397};
    sets[1] = '{16'd65535, 16'd8, 16'd65535, 16'd65535};
    sets[2] = '{16'd0, 16'd1, 16'd0, 16'd0};
    sets[3] = '{16'd20000, 16'd0, 16'd40000, 16'd4096};
    sets[4] = '{16'd1000, 16'd15, 16'd0, 16'd65535};
    sets[5] = '{16'd50000, 16'd3, 16'd20000, 16'd2000};

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // full table load before any evaluation
    for (int i = 0; i < 256; i++) shuf[i] = i[7:0];
    for (int i = 255; i > 0; i--) begin
      j = $urandom_range(i);
      tmp = shuf[i];
      shuf[i] = shuf[j];
      shuf[j] = tmp;
    end
    for (int i = 0; i < 256; i++)
      send(fpn_pkg::OP_LOAD, i[7:0], shuf[i], rand_coord(), rand_coord(), 1'b0, 16'sd0);

    for (int r = 0; r < N_ROWS; r++)
      send(rows[r].op, rows[r].ti, rows[r].tv, rows[r].x, rows[r].y,
           rows[r].known, rows[r].want);

    for (int p = 0; p < 6; p++) begin
      drain();
      write_reg(fpn_pkg::CFG_BASE_FREQ, sets[p][0]);
      write_reg(fpn_pkg::CFG_OCTAVE_COUNT, sets[p][1]);
      write_reg(fpn_pkg::CFG_PERSISTENCE, sets[p][2]);
      write_reg(fpn_pkg::CFG_LACUNARITY, sets[p][3]);
      if (p < 2) begin
        send_idle_pct = 20;
        recv_idle_pct = 62;
      end else if (p < 4) begin
        send_idle_pct = 62;
        recv_idle_pct = 20;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      for (int k = 0; k < 172; k++) begin
        if ($urandom_range(9) == 0)
          send(fpn_pkg::OP_LOAD, 8'($urandom), 8'($urandom), rand_coord(), rand_coord(),
               1'b0, 16'sd0);
        else
          send(fpn_pkg::OP_EVAL, 8'($urandom), 8'($urandom), rand_coord(), rand_coord(),
               1'b0, 16'sd0);
      end
    end

    drain();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### sim.f
rtl/fpn_pkg.sv
rtl/fpn_front.sv
rtl/fpn_div.sv
rtl/fpn_back.sv
rtl/fractal_perlin_noise.sv
tb/sv/tb_fractal_perlin_noise.sv
